>>> rtl/three_level_feedback_thread_scheduler_core_defines.svh
// Assertion macros for the thread scheduler core.
// Used by the top level; needs signals clock and reset in scope.
`ifndef THREE_LEVEL_FEEDBACK_THREAD_SCHEDULER_CORE_DEFINES_SVH
`define THREE_LEVEL_FEEDBACK_THREAD_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define TLFS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tlfs_pkg.sv
// Shared types, codes and helpers for the thread scheduler core.
// No dependencies.
`timescale 1ns / 1ps
package tlfs_pkg;
   localparam int NSLOT  = 32;
   localparam int SLOT_W = 5;
   localparam int KEY_W  = 34;

   localparam logic [3:0] CMD_CREATE  = 4'd0;
   localparam logic [3:0] CMD_CANCEL  = 4'd1;
   localparam logic [3:0] CMD_WAITEV  = 4'd2;
   localparam logic [3:0] CMD_SETEV   = 4'd3;
   localparam logic [3:0] CMD_WAITT   = 4'd4;
   localparam logic [3:0] CMD_RECLAIM = 4'd5;
   localparam logic [3:0] CMD_TESTC   = 4'd6;
   localparam logic [3:0] CMD_TICK    = 4'd7;
   localparam logic [3:0] CMD_READ    = 4'd8;

   localparam logic [1:0] TS_READY = 2'd0;
   localparam logic [1:0] TS_RUN   = 2'd1;
   localparam logic [1:0] TS_WAIT  = 2'd2;
   localparam logic [1:0] TS_TERM  = 2'd3;
   localparam logic [2:0] TS_FREE  = 3'd4;

   localparam logic [1:0] RS_OK    = 2'd0;
   localparam logic [1:0] RS_FULL  = 2'd1;
   localparam logic [1:0] RS_NOMAT = 2'd2;
   localparam logic [1:0] RS_NORUN = 2'd3;

   localparam logic [1:0] CSR_QH = 2'd0;
   localparam logic [1:0] CSR_QM = 2'd1;
   localparam logic [1:0] CSR_QL = 2'd2;
   localparam logic [1:0] CSR_TS = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SEL, S_APPLY, S_DSCAN, S_DSEL, S_DAPPLY, S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  base;
      logic [1:0]  lvl;
      logic [3:0]  qleft;
      logic        defer;
      logic        cpend;
      logic [7:0]  aev;
      logic        onev;
      logic [15:0] tleft;
      logic [31:0] rtot;
      logic [31:0] wtot;
      logic [31:0] stamp;
   } slot_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] idx;
   } pick_type;

   function automatic logic [3:0] quantum_of(input logic [1:0] lvl, input logic [3:0] qh,
                                            input logic [3:0] qm, input logic [3:0] ql);
      logic [3:0] q;
      case (lvl)
         2'd0:    q = qh;
         2'd1:    q = qm;
         default: q = ql;
      endcase
      return q;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [7:0] b);
      logic [32:0] t;
      t = {1'b0, a} + {25'd0, b};
      return t[32] ? 32'hFFFF_FFFF : t[31:0];
   endfunction
endpackage

>>> rtl/tlfs_pick.sv
// Shared compare unit: keeps the best candidate seen during a slot scan.
// Depends on tlfs_pkg.
`timescale 1ns / 1ps
module tlfs_pick (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         cand_valid,
   input  logic [tlfs_pkg::SLOT_W-1:0]  cand_idx,
   input  logic [tlfs_pkg::KEY_W-1:0]   cand_key,
   output tlfs_pkg::pick_type           best
);
   tlfs_pkg::pick_type             best_ff, best_in;
   logic [tlfs_pkg::KEY_W-1:0]     key_ff, key_in;
   logic                           take;

   // strict less keeps the lowest index on ties
   assign take = cand_valid && (!best_ff.valid || cand_key < key_ff);

   always_comb begin
      best_in = best_ff;
      key_in  = key_ff;
      if (clear) begin
         best_in.valid = 1'b0;
      end else if (take) begin
         best_in.valid = 1'b1;
         best_in.idx   = cand_idx;
         key_in        = cand_key;
      end
   end

   always_ff @(posedge clock) begin
      best_ff.idx <= best_in.idx;
      key_ff      <= key_in;
      if (reset) begin
         best_ff.valid <= 1'b0;
      end else begin
         best_ff.valid <= best_in.valid;
      end
   end

   assign best = best_ff;
endmodule

>>> rtl/three_level_feedback_thread_scheduler_core.sv
// Top level of the three-level feedback thread scheduler.
// Depends on tlfs_pkg, tlfs_pick and the assertion macro header.
`timescale 1ns / 1ps
`include "three_level_feedback_thread_scheduler_core_defines.svh"
// A command is taken when start is high and busy is low; busy then stays high
// until the single result beat, which shows on the rsp_ ports for one cycle with
// rsp_valid high and cannot be held off. Read does no search; cancel, the two waits,
// test cancel and unknown codes do one dispatch search; create, set event, reclaim
// and tick do a slot search, then the dispatch search. Each search walks all 32
// slots one per cycle through one shared compare unit. The next command can be
// taken in the cycle after the result beat. Configuration writes go straight to
// the registers and should happen only while idle.
module three_level_feedback_thread_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_command,
   input  logic [1:0]  req_priority_req,
   input  logic        req_cancel_deferred,
   input  logic [4:0]  req_thread_id,
   input  logic [7:0]  req_event_id,
   input  logic [15:0] req_wait_ticks,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_result_id,
   output logic        rsp_running_valid,
   output logic [4:0]  rsp_running_id,
   output logic        rsp_dispatched,
   output logic [2:0]  rsp_thread_state,
   output logic [1:0]  rsp_base_level,
   output logic [1:0]  rsp_current_level,
   output logic [31:0] rsp_ready_time,
   output logic [31:0] rsp_waited_time,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   localparam int SW = tlfs_pkg::SLOT_W;

   tlfs_pkg::state_type state_ff, state_in;

   logic [3:0]  qh_ff, qm_ff, ql_ff;
   logic [7:0]  tstep_ff;

   logic [3:0]  cmd_ff, cmd_in;
   logic [1:0]  prio_ff, prio_in;
   logic        dfr_ff, dfr_in;
   logic [4:0]  tid_ff, tid_in;
   logic [7:0]  ev_ff, ev_in;
   logic [15:0] wt_ff, wt_in;

   logic [SW-1:0] idx_ff, idx_in;
   logic [31:0]   stamp_ff, stamp_in;
   logic [SW-1:0] cur_slot_ff, cur_slot_in;
   logic          cur_valid_ff, cur_valid_in;

   logic [1:0]  res_status_ff, res_status_in;
   logic [4:0]  res_rid_ff, res_rid_in;
   logic        res_disp_ff, res_disp_in;
   logic [2:0]  res_tstate_ff, res_tstate_in;
   logic [1:0]  res_base_ff, res_base_in;
   logic [1:0]  res_lvl_ff, res_lvl_in;
   logic [31:0] res_rt_ff, res_rt_in;
   logic [31:0] res_wt_ff, res_wt_in;

   // slot table, one access port at idx_ff
   logic               used_ff [tlfs_pkg::NSLOT];
   logic [1:0]         stat_ff [tlfs_pkg::NSLOT];
   tlfs_pkg::slot_type rec_ff  [tlfs_pkg::NSLOT];

   logic               cur_used;
   logic [1:0]         cur_stat;
   tlfs_pkg::slot_type cur_rec;
   logic               wr_en, wr_used;
   logic [1:0]         wr_stat;
   tlfs_pkg::slot_type wr_rec;

   logic                         pick_clear, cand_valid;
   logic [tlfs_pkg::KEY_W-1:0]   cand_key;
   tlfs_pkg::pick_type           best;
   logic                         last;
   logic [1:0]                   lv;
   logic                         run_slot_ok;

   assign cur_used = used_ff[idx_ff];
   assign cur_stat = stat_ff[idx_ff];
   assign cur_rec  = rec_ff[idx_ff];
   assign last     = (idx_ff == SW'(tlfs_pkg::NSLOT - 1));

   tlfs_pick u_pick (
      .clock      (clock),
      .reset      (reset),
      .clear      (pick_clear),
      .cand_valid (cand_valid),
      .cand_idx   (idx_ff),
      .cand_key   (cand_key),
      .best       (best)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      prio_in       = prio_ff;
      dfr_in        = dfr_ff;
      tid_in        = tid_ff;
      ev_in         = ev_ff;
      wt_in         = wt_ff;
      idx_in        = idx_ff;
      stamp_in      = stamp_ff;
      cur_slot_in   = cur_slot_ff;
      cur_valid_in  = cur_valid_ff;
      res_status_in = res_status_ff;
      res_rid_in    = res_rid_ff;
      res_disp_in   = res_disp_ff;
      res_tstate_in = res_tstate_ff;
      res_base_in   = res_base_ff;
      res_lvl_in    = res_lvl_ff;
      res_rt_in     = res_rt_ff;
      res_wt_in     = res_wt_ff;
      wr_en         = 1'b0;
      wr_used       = cur_used;
      wr_stat       = cur_stat;
      wr_rec        = cur_rec;
      pick_clear    = 1'b0;
      cand_valid    = 1'b0;
      cand_key      = {2'd0, cur_rec.stamp} | {cur_rec.lvl, 32'd0};
      lv            = cur_rec.lvl;

      case (state_ff)
         tlfs_pkg::S_IDLE: begin
            pick_clear = 1'b1;
            if (start) begin
               cmd_in        = req_command;
               prio_in       = req_priority_req;
               dfr_in        = req_cancel_deferred;
               tid_in        = req_thread_id;
               ev_in         = req_event_id;
               wt_in         = req_wait_ticks;
               res_status_in = tlfs_pkg::RS_OK;
               res_rid_in    = 5'd0;
               res_disp_in   = 1'b0;
               res_tstate_in = 3'd0;
               res_base_in   = 2'd0;
               res_lvl_in    = 2'd0;
               res_rt_in     = 32'd0;
               res_wt_in     = 32'd0;
               case (req_command)
                  tlfs_pkg::CMD_CREATE, tlfs_pkg::CMD_SETEV,
                  tlfs_pkg::CMD_RECLAIM, tlfs_pkg::CMD_TICK: begin
                     idx_in   = '0;
                     state_in = tlfs_pkg::S_SCAN;
                  end
                  tlfs_pkg::CMD_CANCEL, tlfs_pkg::CMD_READ: begin
                     idx_in   = req_thread_id;
                     state_in = tlfs_pkg::S_APPLY;
                  end
                  default: begin
                     idx_in   = cur_slot_ff;
                     state_in = tlfs_pkg::S_APPLY;
                  end
               endcase
            end
         end

         tlfs_pkg::S_SCAN: begin
            case (cmd_ff)
               tlfs_pkg::CMD_CREATE: begin
                  cand_valid = !cur_used;
                  cand_key   = '0;
               end
               tlfs_pkg::CMD_SETEV: begin
                  cand_valid = cur_used && cur_stat == tlfs_pkg::TS_WAIT &&
                               cur_rec.onev && cur_rec.aev == ev_ff;
               end
               tlfs_pkg::CMD_RECLAIM: begin
                  cand_valid = cur_used && cur_stat == tlfs_pkg::TS_TERM;
               end
               default: begin
                  // tick: age totals and count down timed waits
                  if (cur_used && cur_stat == tlfs_pkg::TS_WAIT) begin
                     wr_en       = 1'b1;
                     wr_rec.wtot = tlfs_pkg::sat_add(cur_rec.wtot, tstep_ff);
                     if (cur_rec.tleft != 16'd0) begin
                        wr_rec.tleft = cur_rec.tleft - 16'd1;
                        if (cur_rec.tleft == 16'd1) begin
                           wr_stat = tlfs_pkg::TS_READY;
                        end
                     end
                  end else if (cur_used && cur_stat == tlfs_pkg::TS_READY) begin
                     wr_en       = 1'b1;
                     wr_rec.rtot = tlfs_pkg::sat_add(cur_rec.rtot, tstep_ff);
                  end
               end
            endcase
            if (last) begin
               state_in = tlfs_pkg::S_SEL;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end

         tlfs_pkg::S_SEL: begin
            idx_in   = (cmd_ff == tlfs_pkg::CMD_TICK) ? cur_slot_ff : best.idx;
            state_in = tlfs_pkg::S_APPLY;
         end

         tlfs_pkg::S_APPLY: begin
            case (cmd_ff)
               tlfs_pkg::CMD_CREATE: begin
                  if (!best.valid) begin
                     res_status_in = tlfs_pkg::RS_FULL;
                  end else begin
                     lv           = (prio_ff == 2'd3) ? 2'd2 : prio_ff;
                     wr_en        = 1'b1;
                     wr_used      = 1'b1;
                     wr_stat      = tlfs_pkg::TS_READY;
                     wr_rec.base  = lv;
                     wr_rec.lvl   = lv;
                     wr_rec.qleft = tlfs_pkg::quantum_of(lv, qh_ff, qm_ff, ql_ff);
                     wr_rec.defer = dfr_ff;
                     wr_rec.cpend = 1'b0;
                     wr_rec.aev   = 8'd0;
                     wr_rec.onev  = 1'b0;
                     wr_rec.tleft = 16'd0;
                     wr_rec.rtot  = 32'd0;
                     wr_rec.wtot  = 32'd0;
                     wr_rec.stamp = stamp_ff;
                     stamp_in     = stamp_ff + 32'd1;
                     res_rid_in   = idx_ff;
                  end
               end
               tlfs_pkg::CMD_CANCEL: begin
                  res_rid_in = tid_ff;
                  if (!cur_used || cur_stat == tlfs_pkg::TS_TERM) begin
                     res_status_in = tlfs_pkg::RS_NOMAT;
                  end else if (cur_rec.defer) begin
                     wr_en        = 1'b1;
                     wr_rec.cpend = 1'b1;
                  end else begin
                     if (cur_stat == tlfs_pkg::TS_RUN) begin
                        cur_valid_in = 1'b0;
                     end
                     wr_en        = 1'b1;
                     wr_stat      = tlfs_pkg::TS_TERM;
                     wr_rec.onev  = 1'b0;
                     wr_rec.tleft = 16'd0;
                  end
               end
               tlfs_pkg::CMD_WAITEV, tlfs_pkg::CMD_WAITT, tlfs_pkg::CMD_TESTC: begin
                  if (!cur_valid_ff) begin
                     res_status_in = tlfs_pkg::RS_NORUN;
                  end else begin
                     res_rid_in = idx_ff;
                     if (cmd_ff == tlfs_pkg::CMD_WAITEV) begin
                        // promote one level, rear of queue
                        lv           = (cur_rec.lvl == 2'd0) ? 2'd0 : cur_rec.lvl - 2'd1;
                        wr_en        = 1'b1;
                        wr_stat      = tlfs_pkg::TS_WAIT;
                        wr_rec.aev   = ev_ff;
                        wr_rec.onev  = 1'b1;
                        wr_rec.tleft = 16'd0;
                        wr_rec.lvl   = lv;
                        wr_rec.qleft = tlfs_pkg::quantum_of(lv, qh_ff, qm_ff, ql_ff);
                        wr_rec.stamp = stamp_ff;
                        stamp_in     = stamp_ff + 32'd1;
                        cur_valid_in = 1'b0;
                     end else if (cmd_ff == tlfs_pkg::CMD_WAITT) begin
                        wr_en        = 1'b1;
                        wr_stat      = tlfs_pkg::TS_WAIT;
                        wr_rec.onev  = 1'b0;
                        wr_rec.tleft = (wt_ff == 16'd0) ? 16'd1 : wt_ff;
                        cur_valid_in = 1'b0;
                     end else if (cur_rec.cpend) begin
                        wr_en        = 1'b1;
                        wr_stat      = tlfs_pkg::TS_TERM;
                        cur_valid_in = 1'b0;
                     end
                  end
               end
               tlfs_pkg::CMD_SETEV: begin
                  if (!best.valid) begin
                     res_status_in = tlfs_pkg::RS_NOMAT;
                  end else begin
                     wr_en       = 1'b1;
                     wr_stat     = tlfs_pkg::TS_READY;
                     wr_rec.onev = 1'b0;
                     res_rid_in  = idx_ff;
                  end
               end
               tlfs_pkg::CMD_RECLAIM: begin
                  if (!best.valid) begin
                     res_status_in = tlfs_pkg::RS_NOMAT;
                  end else begin
                     wr_en      = 1'b1;
                     wr_used    = 1'b0;
                     wr_stat    = tlfs_pkg::TS_READY;
                     res_rid_in = idx_ff;
                  end
               end
               tlfs_pkg::CMD_TICK: begin
                  if (cur_valid_ff) begin
                     wr_en = 1'b1;
                     if (cur_rec.qleft <= 4'd1) begin
                        // quantum used up: demote, requeue at rear
                        lv           = (cur_rec.lvl >= 2'd2) ? 2'd2 : cur_rec.lvl + 2'd1;
                        wr_stat      = tlfs_pkg::TS_READY;
                        wr_rec.lvl   = lv;
                        wr_rec.qleft = tlfs_pkg::quantum_of(lv, qh_ff, qm_ff, ql_ff);
                        wr_rec.stamp = stamp_ff;
                        stamp_in     = stamp_ff + 32'd1;
                        cur_valid_in = 1'b0;
                     end else begin
                        wr_rec.qleft = cur_rec.qleft - 4'd1;
                     end
                  end
               end
               tlfs_pkg::CMD_READ: begin
                  res_rid_in = tid_ff;
                  if (!cur_used) begin
                     res_tstate_in = tlfs_pkg::TS_FREE;
                  end else begin
                     res_tstate_in = {1'b0, cur_stat};
                     res_base_in   = cur_rec.base;
                     res_lvl_in    = cur_rec.lvl;
                     res_rt_in     = cur_rec.rtot;
                     res_wt_in     = cur_rec.wtot;
                  end
               end
               default: begin
               end
            endcase
            if (cmd_ff == tlfs_pkg::CMD_READ) begin
               state_in = tlfs_pkg::S_RESP;
            end else begin
               pick_clear = 1'b1;
               idx_in     = '0;
               state_in   = tlfs_pkg::S_DSCAN;
            end
         end

         tlfs_pkg::S_DSCAN: begin
            cand_valid = cur_used && cur_stat == tlfs_pkg::TS_READY;
            if (last) begin
               state_in = tlfs_pkg::S_DSEL;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end

         tlfs_pkg::S_DSEL: begin
            idx_in   = best.idx;
            state_in = tlfs_pkg::S_DAPPLY;
         end

         tlfs_pkg::S_DAPPLY: begin
            if (!cur_valid_ff && best.valid) begin
               wr_en        = 1'b1;
               wr_stat      = tlfs_pkg::TS_RUN;
               cur_slot_in  = idx_ff;
               cur_valid_in = 1'b1;
               res_disp_in  = 1'b1;
            end
            state_in = tlfs_pkg::S_RESP;
         end

         tlfs_pkg::S_RESP: begin
            state_in = tlfs_pkg::S_IDLE;
         end

         default: begin
            state_in = tlfs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlfs_pkg::S_IDLE;
         stamp_ff     <= 32'd0;
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         qh_ff        <= 4'd1;
         qm_ff        <= 4'd2;
         ql_ff        <= 4'd3;
         tstep_ff     <= 8'd10;
      end else begin
         state_ff     <= state_in;
         stamp_ff     <= stamp_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               tlfs_pkg::CSR_QH: qh_ff    <= csr_write_data[3:0];
               tlfs_pkg::CSR_QM: qm_ff    <= csr_write_data[3:0];
               tlfs_pkg::CSR_QL: ql_ff    <= csr_write_data[3:0];
               default:          tstep_ff <= csr_write_data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      prio_ff       <= prio_in;
      dfr_ff        <= dfr_in;
      tid_ff        <= tid_in;
      ev_ff         <= ev_in;
      wt_ff         <= wt_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_rid_ff    <= res_rid_in;
      res_disp_ff   <= res_disp_in;
      res_tstate_ff <= res_tstate_in;
      res_base_ff   <= res_base_in;
      res_lvl_ff    <= res_lvl_in;
      res_rt_ff     <= res_rt_in;
      res_wt_ff     <= res_wt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tlfs_pkg::NSLOT; i++) begin
            used_ff[i] <= 1'b0;
            stat_ff[i] <= tlfs_pkg::TS_READY;
         end
      end else if (wr_en) begin
         used_ff[idx_ff] <= wr_used;
         stat_ff[idx_ff] <= wr_stat;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_ff[idx_ff] <= wr_rec;
      end
   end

   assign busy              = (state_ff != tlfs_pkg::S_IDLE);
   assign rsp_valid         = (state_ff == tlfs_pkg::S_RESP);
   assign rsp_status        = res_status_ff;
   assign rsp_result_id     = res_rid_ff;
   assign rsp_running_valid = cur_valid_ff;
   assign rsp_running_id    = cur_valid_ff ? cur_slot_ff : 5'd0;
   assign rsp_dispatched    = res_disp_ff;
   assign rsp_thread_state  = res_tstate_ff;
   assign rsp_base_level    = res_base_ff;
   assign rsp_current_level = res_lvl_ff;
   assign rsp_ready_time    = res_rt_ff;
   assign rsp_waited_time   = res_wt_ff;

   assign run_slot_ok = used_ff[cur_slot_ff] && stat_ff[cur_slot_ff] == tlfs_pkg::TS_RUN;

   `TLFS_ASSERT_NOW(a_run_slot, cur_valid_ff, run_slot_ok, "running slot not running")
   `TLFS_ASSERT_NOW(a_disp_run, rsp_valid && rsp_dispatched, rsp_running_valid, "bad dispatch")
   `TLFS_ASSERT_NEXT(a_take, start && !busy, busy, "command not taken")
   `TLFS_ASSERT_NEXT(a_resp_end, rsp_valid, !busy && !rsp_valid, "result beat not single")
endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for the three-level feedback thread scheduler core.
// Depends on tlfs_pkg and three_level_feedback_thread_scheduler_core.
`timescale 1ns / 1ps
module testbench;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  result_id;
      logic        running_valid;
      logic [4:0]  running_id;
      logic        dispatched;
      logic [2:0]  thread_state;
      logic [1:0]  base_level;
      logic [1:0]  current_level;
      logic [31:0] ready_time;
      logic [31:0] waited_time;
   } sched_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_command = '0;
   logic [1:0]  req_priority_req = '0;
   logic        req_cancel_deferred = 1'b0;
   logic [4:0]  req_thread_id = '0;
   logic [7:0]  req_event_id = '0;
   logic [15:0] req_wait_ticks = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_result_id;
   logic        rsp_running_valid;
   logic [4:0]  rsp_running_id;
   logic        rsp_dispatched;
   logic [2:0]  rsp_thread_state;
   logic [1:0]  rsp_base_level;
   logic [1:0]  rsp_current_level;
   logic [31:0] rsp_ready_time;
   logic [31:0] rsp_waited_time;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_write_data = '0;

   three_level_feedback_thread_scheduler_core DUT (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // scheduler shadow state
   logic        live[tlfs_pkg::NSLOT];
   logic [1:0]  sstate[tlfs_pkg::NSLOT];
   logic [1:0]  sbase[tlfs_pkg::NSLOT];
   logic [1:0]  slevel[tlfs_pkg::NSLOT];
   logic [3:0]  sqleft[tlfs_pkg::NSLOT];
   logic        sdefer[tlfs_pkg::NSLOT];
   logic        scpend[tlfs_pkg::NSLOT];
   logic [7:0]  sev[tlfs_pkg::NSLOT];
   logic        sonev[tlfs_pkg::NSLOT];
   logic [15:0] stleft[tlfs_pkg::NSLOT];
   logic [31:0] srtot[tlfs_pkg::NSLOT];
   logic [31:0] swtot[tlfs_pkg::NSLOT];
   logic [31:0] sstamp[tlfs_pkg::NSLOT];
   logic [31:0] stamp_next;
   logic [4:0]  run_slot;
   logic        run_ok;
   logic [3:0]  q_hi, q_mid, q_lo;
   logic [7:0]  tstep;

   sched_beat_type expected_beats[$];
   int          errors = 0;
   int          burst_left = 0;

   function automatic logic [3:0] level_quantum(logic [1:0] lv);
      return lv == 2'd0 ? q_hi : (lv == 2'd1 ? q_mid : q_lo);
   endfunction

   function automatic logic [31:0] add_sat(logic [31:0] a, logic [7:0] b);
      logic [32:0] t;
      t = {1'b0, a} + {25'd0, b};
      return t[32] ? 32'hFFFF_FFFF : t[31:0];
   endfunction

   // front of the highest non-empty level holding the given state
   function automatic int first_in_state(logic [1:0] want, bit need_ev, logic [7:0] ev);
      int best;
      for (int lv = 0; lv < 3; lv++) begin
         best = -1;
         for (int i = 0; i < tlfs_pkg::NSLOT; i++) begin
            if (!live[i] || sstate[i] != want || slevel[i] != lv) continue;
            if (need_ev && !(sonev[i] && sev[i] == ev)) continue;
            if (best < 0 || sstamp[i] < sstamp[best]) best = i;
         end
         if (best >= 0) return best;
      end
      return -1;
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < tlfs_pkg::NSLOT; i++) begin
         live[i] = 1'b0; sstate[i] = tlfs_pkg::TS_READY;
      end
      stamp_next = 32'd0; run_slot = 5'd0; run_ok = 1'b0;
      q_hi = 4'd1; q_mid = 4'd2; q_lo = 4'd3; tstep = 8'd10;
   endfunction

   function automatic sched_beat_type schedule_step(logic [3:0] cmd, logic [1:0] prio,
         logic dfr, logic [4:0] tid, logic [7:0] ev, logic [15:0] wt);
      sched_beat_type r;
      int s;
      logic [1:0] lv;
      r = '0;
      case (cmd)
         tlfs_pkg::CMD_CREATE: begin
            s = -1;
            for (int i = tlfs_pkg::NSLOT - 1; i >= 0; i--) if (!live[i]) s = i;
            if (s < 0) r.status = tlfs_pkg::RS_FULL;
            else begin
               lv = prio > 2'd2 ? 2'd2 : prio;
               live[s] = 1'b1; sstate[s] = tlfs_pkg::TS_READY; sbase[s] = lv;
               slevel[s] = lv;
               sqleft[s] = level_quantum(lv); sdefer[s] = dfr; scpend[s] = 1'b0;
               sev[s] = 8'd0; sonev[s] = 1'b0; stleft[s] = 16'd0;
               srtot[s] = 32'd0; swtot[s] = 32'd0;
               sstamp[s] = stamp_next; stamp_next++;
               r.result_id = 5'(s);
            end
         end
         tlfs_pkg::CMD_CANCEL: begin
            r.result_id = tid;
            if (!live[tid] || sstate[tid] == tlfs_pkg::TS_TERM) r.status = tlfs_pkg::RS_NOMAT;
            else if (sdefer[tid]) scpend[tid] = 1'b1;
            else begin
               if (sstate[tid] == tlfs_pkg::TS_RUN) run_ok = 1'b0;
               sstate[tid] = tlfs_pkg::TS_TERM; sonev[tid] = 1'b0; stleft[tid] = 16'd0;
            end
         end
         tlfs_pkg::CMD_WAITEV, tlfs_pkg::CMD_WAITT, tlfs_pkg::CMD_TESTC: begin
            if (!run_ok) r.status = tlfs_pkg::RS_NORUN;
            else begin
               r.result_id = run_slot;
               if (cmd == tlfs_pkg::CMD_WAITEV) begin
                  lv = slevel[run_slot] == 2'd0 ? 2'd0 : slevel[run_slot] - 2'd1;
                  sstate[run_slot] = tlfs_pkg::TS_WAIT; sev[run_slot] = ev;
                  sonev[run_slot] = 1'b1;
                  stleft[run_slot] = 16'd0; slevel[run_slot] = lv;
                  sqleft[run_slot] = level_quantum(lv);
                  sstamp[run_slot] = stamp_next; stamp_next++;
                  run_ok = 1'b0;
               end else if (cmd == tlfs_pkg::CMD_WAITT) begin
                  sstate[run_slot] = tlfs_pkg::TS_WAIT; sonev[run_slot] = 1'b0;
                  stleft[run_slot] = wt == 16'd0 ? 16'd1 : wt;
                  run_ok = 1'b0;
               end else if (scpend[run_slot]) begin
                  sstate[run_slot] = tlfs_pkg::TS_TERM; run_ok = 1'b0;
               end
            end
         end
         tlfs_pkg::CMD_SETEV: begin
            s = first_in_state(tlfs_pkg::TS_WAIT, 1'b1, ev);
            if (s < 0) r.status = tlfs_pkg::RS_NOMAT;
            else begin
               sstate[s] = tlfs_pkg::TS_READY; sonev[s] = 1'b0; r.result_id = 5'(s);
            end
         end
         tlfs_pkg::CMD_RECLAIM: begin
            s = first_in_state(tlfs_pkg::TS_TERM, 1'b0, 8'd0);
            if (s < 0) r.status = tlfs_pkg::RS_NOMAT;
            else begin
               live[s] = 1'b0; sstate[s] = tlfs_pkg::TS_READY; r.result_id = 5'(s);
            end
         end
         tlfs_pkg::CMD_TICK: begin
            for (int i = 0; i < tlfs_pkg::NSLOT; i++) begin
               if (!live[i]) continue;
               if (sstate[i] == tlfs_pkg::TS_WAIT) begin
                  swtot[i] = add_sat(swtot[i], tstep);
                  if (stleft[i] != 16'd0) begin
                     stleft[i]--;
                     if (stleft[i] == 16'd0) sstate[i] = tlfs_pkg::TS_READY;
                  end
               end else if (sstate[i] == tlfs_pkg::TS_READY) begin
                  srtot[i] = add_sat(srtot[i], tstep);
               end
            end
            if (run_ok) begin
               if (sqleft[run_slot] <= 4'd1) begin
                  lv = slevel[run_slot] >= 2'd2 ? 2'd2 : slevel[run_slot] + 2'd1;
                  sstate[run_slot] = tlfs_pkg::TS_READY; slevel[run_slot] = lv;
                  sqleft[run_slot] = level_quantum(lv);
                  sstamp[run_slot] = stamp_next; stamp_next++;
                  run_ok = 1'b0;
               end else sqleft[run_slot]--;
            end
         end
         tlfs_pkg::CMD_READ: begin
            r.result_id = tid;
            if (!live[tid]) r.thread_state = tlfs_pkg::TS_FREE;
            else begin
               r.thread_state = {1'b0, sstate[tid]};
               r.base_level = sbase[tid]; r.current_level = slevel[tid];
               r.ready_time = srtot[tid]; r.waited_time = swtot[tid];
            end
         end
         default: ;
      endcase
      if (cmd != tlfs_pkg::CMD_READ && !run_ok) begin
         s = first_in_state(tlfs_pkg::TS_READY, 1'b0, 8'd0);
         if (s >= 0) begin
            sstate[s] = tlfs_pkg::TS_RUN; run_slot = 5'(s); run_ok = 1'b1;
            r.dispatched = 1'b1;
         end
      end
      r.running_valid = run_ok;
      r.running_id = run_ok ? run_slot : 5'd0;
      return r;
   endfunction

   // predict on every accepted command and track every register write
   always @(posedge clock) begin
      if (reset) clear_shadow();
      else begin
         if (csr_write_enable) begin
            case (csr_index)
               tlfs_pkg::CSR_QH: q_hi = csr_write_data[3:0];
               tlfs_pkg::CSR_QM: q_mid = csr_write_data[3:0];
               tlfs_pkg::CSR_QL: q_lo = csr_write_data[3:0];
               default: tstep = csr_write_data;
            endcase
         end
         if (start && !busy)
            expected_beats.push_back(schedule_step(req_command, req_priority_req,
               req_cancel_deferred, req_thread_id, req_event_id, req_wait_ticks));
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      sched_beat_type e;
      if (!reset && rsp_valid) begin
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            e = expected_beats.pop_front();
            check_field("status", 32'(e.status), 32'(rsp_status));
            check_field("result_id", 32'(e.result_id), 32'(rsp_result_id));
            check_field("running_valid", 32'(e.running_valid), 32'(rsp_running_valid));
            check_field("running_id", 32'(e.running_id), 32'(rsp_running_id));
            check_field("dispatched", 32'(e.dispatched), 32'(rsp_dispatched));
            check_field("thread_state", 32'(e.thread_state), 32'(rsp_thread_state));
            check_field("base_level", 32'(e.base_level), 32'(rsp_base_level));
            check_field("current_level", 32'(e.current_level), 32'(rsp_current_level));
            check_field("ready_time", e.ready_time, rsp_ready_time);
            check_field("waited_time", e.waited_time, rsp_waited_time);
         end
      end
   end

   // one command beat; bursts of back-to-back beats split by random gaps
   task automatic send_cmd(logic [3:0] cmd, logic [1:0] prio = 2'd0, logic dfr = 1'b0,
         logic [4:0] tid = 5'd0, logic [7:0] ev = 8'd0, logic [15:0] wt = 16'd0);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
         if (start && gap != 0) start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      start <= 1'b1;
      req_command <= cmd; req_priority_req <= prio; req_cancel_deferred <= dfr;
      req_thread_id <= tid; req_event_id <= ev; req_wait_ticks <= wt;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      if (start) start <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      csr_write_enable <= 1'b1; csr_index <= idx; csr_write_data <= val;
      @(posedge clock);
   endtask

   task automatic set_config(logic [3:0] qh, logic [3:0] qm, logic [3:0] ql, logic [7:0] ts);
      drain();
      @(posedge clock);
      write_reg(tlfs_pkg::CSR_QH, {4'd0, qh});
      write_reg(tlfs_pkg::CSR_QM, {4'd0, qm});
      write_reg(tlfs_pkg::CSR_QL, {4'd0, ql});
      write_reg(tlfs_pkg::CSR_TS, ts);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_directed();
      send_cmd(tlfs_pkg::CMD_READ, 2'd0, 1'b0, 5'd31);             // free slot
      send_cmd(tlfs_pkg::CMD_WAITEV);                              // nothing running
      send_cmd(tlfs_pkg::CMD_RECLAIM);                             // nothing terminated
      send_cmd(tlfs_pkg::CMD_CREATE, 2'd2, 1'b0);
      send_cmd(tlfs_pkg::CMD_CREATE, 2'd0, 1'b1);
      send_cmd(tlfs_pkg::CMD_CREATE, 2'd1, 1'b0);
      send_cmd(tlfs_pkg::CMD_CREATE, 2'd3, 1'b1);                  // priority three -> low
      send_cmd(tlfs_pkg::CMD_TICK);
      send_cmd(tlfs_pkg::CMD_TICK);
      send_cmd(tlfs_pkg::CMD_WAITEV, 2'd0, 1'b0, 5'd0, 8'hFF);
      send_cmd(tlfs_pkg::CMD_SETEV, 2'd0, 1'b0, 5'd0, 8'h00);      // no waiter on it
      send_cmd(tlfs_pkg::CMD_SETEV, 2'd0, 1'b0, 5'd0, 8'hFF);
      send_cmd(tlfs_pkg::CMD_WAITT, 2'd0, 1'b0, 5'd0, 8'd0, 16'd0); // zero acts as one
      send_cmd(tlfs_pkg::CMD_TICK);
      send_cmd(tlfs_pkg::CMD_WAITT, 2'd0, 1'b0, 5'd0, 8'd0, 16'hFFFF);
      send_cmd(tlfs_pkg::CMD_CANCEL, 2'd0, 1'b0, 5'd1);            // deferred: pending only
      send_cmd(tlfs_pkg::CMD_TESTC);
      send_cmd(tlfs_pkg::CMD_CANCEL, 2'd0, 1'b0, 5'd2);
      send_cmd(tlfs_pkg::CMD_CANCEL, 2'd0, 1'b0, 5'd30);           // free target
      send_cmd(tlfs_pkg::CMD_RECLAIM);
      send_cmd(4'd9);
      send_cmd(4'd15);
      for (int i = 0; i < 4; i++) send_cmd(tlfs_pkg::CMD_READ, 2'd0, 1'b0, i[4:0]);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < tlfs_pkg::NSLOT + 2; i++)
         send_cmd(tlfs_pkg::CMD_CREATE, i[1:0], i[0]);
      for (int i = 0; i < tlfs_pkg::NSLOT; i++)
         send_cmd(tlfs_pkg::CMD_CANCEL, 2'd0, 1'b0, i[4:0]);
      for (int i = 0; i < 40; i++) begin
         send_cmd(tlfs_pkg::CMD_TESTC);
         send_cmd(tlfs_pkg::CMD_RECLAIM);
      end
   endtask

   task automatic random_cmd();
      int p;
      logic [3:0] cmd;
      logic [7:0] ev;
      logic [15:0] wt;
      p = $urandom_range(0, 99);
      if (p < 16) cmd = tlfs_pkg::CMD_CREATE;
      else if (p < 24) cmd = tlfs_pkg::CMD_CANCEL;
      else if (p < 34) cmd = tlfs_pkg::CMD_WAITEV;
      else if (p < 46) cmd = tlfs_pkg::CMD_SETEV;
      else if (p < 53) cmd = tlfs_pkg::CMD_WAITT;
      else if (p < 59) cmd = tlfs_pkg::CMD_RECLAIM;
      else if (p < 65) cmd = tlfs_pkg::CMD_TESTC;
      else if (p < 88) cmd = tlfs_pkg::CMD_TICK;
      else if (p < 97) cmd = tlfs_pkg::CMD_READ;
      else cmd = 4'($urandom_range(9, 15));
      // few events so that set event usually finds a waiter
      ev = $urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
      wt = $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(0, 6));
      send_cmd(cmd, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               5'($urandom_range(0, 31)), ev, wt);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) random_cmd();
   endtask

   task automatic test_config_sweep();
      set_config(4'd0, 4'd0, 4'd0, 8'd0);
      test_random(90);
      set_config(4'd15, 4'd15, 4'd15, 8'd255);
      test_random(90);
      for (int k = 0; k < 3; k++) begin
         set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         test_random(90);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_random(120);
      test_config_sweep();
      drain();
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end
endmodule
